/* rtl/core/rxpf_pkg.sv */
// Shared types and constants for the receive framer with byte ring.
`timescale 1ns / 1ps

package rxpf_pkg;

  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  localparam logic [7:0] MARK_START = 8'hCC;
  localparam logic [7:0] MARK_TAIL  = 8'hB9;
  localparam logic [7:0] MARK_END1  = 8'h0D;
  localparam logic [7:0] MARK_END2  = 8'h0A;

  typedef enum logic [1:0] {
    ACT_RX      = 2'd0,
    ACT_READ    = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    FS_NONE  = 2'd0,
    FS_DONE  = 2'd1,
    FS_ABORT = 2'd2
  } status_e;

  // Tracker verdict for one received byte.
  typedef struct packed {
    status_e status;
    logic    set_latch;
  } trk_res_t;

endpackage

/* rtl/core/rxpf_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module rxpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/rxpf_tracker.sv */
// Frame tracker: start, length, payload, tail, checksum, CR, LF.
`timescale 1ns / 1ps

module rxpf_tracker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [7:0]       data_i,
  output rxpf_pkg::trk_res_t res_o
);
  import rxpf_pkg::*;

  typedef enum logic [2:0] {
    ST_WAIT     = 3'd0,
    ST_LEN      = 3'd1,
    ST_PAYLOAD  = 3'd2,
    ST_TAIL     = 3'd3,
    ST_CHECKSUM = 3'd4,
    ST_END1     = 3'd5,
    ST_END2     = 3'd6
  } step_e;

  step_e      step_q, step_d;
  logic [7:0] left_q, left_d;
  logic [7:0] left_dec;
  trk_res_t   res;

  always_comb begin
    step_d        = step_q;
    left_d        = left_q;
    res.status    = FS_NONE;
    res.set_latch = 1'b0;
    left_dec      = (left_q != 8'd0) ? (left_q - 8'd1) : left_q;
    unique case (step_q)
      ST_WAIT: begin
        if (data_i == MARK_START) step_d = ST_LEN;
      end
      ST_LEN: begin
        left_d = data_i;
        step_d = (data_i == 8'd0) ? ST_TAIL : ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        left_d = left_dec;
        if (left_dec == 8'd0) step_d = ST_TAIL;
      end
      ST_TAIL: begin
        if (data_i == MARK_TAIL) begin
          step_d = ST_CHECKSUM;
        end else begin
          step_d        = ST_WAIT;
          res.status    = FS_ABORT;
          res.set_latch = 1'b1;
        end
      end
      ST_CHECKSUM: step_d = ST_END1;
      ST_END1: begin
        if (data_i == MARK_END1) begin
          step_d = ST_END2;
        end else begin
          step_d        = ST_WAIT;
          res.status    = FS_ABORT;
          res.set_latch = 1'b1;
        end
      end
      ST_END2: begin
        // bad LF keeps waiting for LF
        if (data_i == MARK_END2) begin
          step_d        = ST_WAIT;
          res.status    = FS_DONE;
          res.set_latch = 1'b1;
        end
      end
      default: step_d = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_WAIT;
      left_q <= 8'd0;
    end else if (en_i) begin
      step_q <= step_d;
      left_q <= left_d;
    end
  end

  assign res_o = res;

endmodule

/* rtl/core/rx_packet_framer_with_ring_buffer_top.sv */
// Top level of the receive framer with byte ring.
`timescale 1ns / 1ps

// Receive framer with a byte ring.
// Input channel (in_valid_i/in_ready_o) carries one beat per item: action_i
// selects received byte, read of the oldest buffered byte, or frame release;
// data_byte_i is the received byte. Output channel (out_valid_o/out_ready_i)
// returns exactly one result beat per input beat, in order.
// Timing: the result of a beat is registered at the edge that accepts it.
// Throughput: one beat per cycle unless the output stalls; all state update
// happens in a single pass between the input handshake and the result
// register, and the ring memory's registered read lines up with that register.
// Stall: when the receiver holds out_ready_i low, the result register holds
// and in_ready_o drops until it is taken; the popped byte stays in the RAM
// read register since no new read is issued meanwhile.
// Reset (rst_ni low, async): pointers, full flag, tracker, frame latch and
// the output valid clear. Ring contents are not cleared; only written bytes
// are ever read back. No clearing pass is needed.
// While a frame is latched, received bytes are dropped without touching the
// ring or tracker; a release beat reopens reception.
module rx_packet_framer_with_ring_buffer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_byte_o,
  output logic       read_valid_o,
  output logic       byte_stored_o,
  output logic [1:0] frame_status_o,
  output logic       frame_latched_o
);
  import rxpf_pkg::*;

  logic               accept;
  action_e            act;
  logic [RING_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [RING_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [RING_AW-1:0] rd_ptr_nxt, wr_ptr_nxt;
  logic               full_q, full_d;
  logic               latch_q, latch_d;
  logic               empty;
  logic               do_push, do_pop, trk_en;
  trk_res_t           trk_res;
  logic [7:0]         ram_rdata;

  // result register
  logic               out_valid_q;
  logic               rd_valid_q, rd_valid_d;
  logic               stored_q, stored_d;
  status_e            status_q, status_d;
  logic               latched_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign act        = action_e'(action_i);

  assign empty = !full_q && (rd_ptr_q == wr_ptr_q);

  assign rd_ptr_nxt = (rd_ptr_q == RING_AW'(RING_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
  assign wr_ptr_nxt = (wr_ptr_q == RING_AW'(RING_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;

  // Byte path runs only while no frame is latched; ring full drops the byte
  // but the tracker still sees it.
  assign trk_en  = accept && (act == ACT_RX) && !latch_q;
  assign do_push = trk_en && !full_q;
  assign do_pop  = accept && (act == ACT_READ) && !empty;

  always_comb begin
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    full_d     = full_q;
    latch_d    = latch_q;
    rd_valid_d = 1'b0;
    stored_d   = 1'b0;
    status_d   = FS_NONE;
    unique case (act)
      ACT_RX: begin
        if (!latch_q) begin
          status_d = trk_res.status;
          if (trk_res.set_latch) latch_d = 1'b1;
          if (!full_q) begin
            stored_d = 1'b1;
            wr_ptr_d = wr_ptr_nxt;
            if (wr_ptr_nxt == rd_ptr_q) full_d = 1'b1;
          end
        end
      end
      ACT_READ: begin
        if (!empty) begin
          rd_valid_d = 1'b1;
          rd_ptr_d   = rd_ptr_nxt;
          full_d     = 1'b0;
        end
      end
      ACT_RELEASE: latch_d = 1'b0;
      default: ;  // unused code: no effect
    endcase
  end

  rxpf_tracker u_tracker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (trk_en),
    .data_i (data_byte_i),
    .res_o  (trk_res)
  );

  rxpf_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (wr_ptr_q),
    .wdata_i (data_byte_i),
    .re_i    (do_pop),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      full_q      <= 1'b0;
      latch_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        rd_ptr_q <= rd_ptr_d;
        wr_ptr_q <= wr_ptr_d;
        full_q   <= full_d;
        latch_q  <= latch_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_valid_q <= rd_valid_d;
      stored_q   <= stored_d;
      status_q   <= status_d;
      latched_q  <= latch_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_byte_o     = rd_valid_q ? ram_rdata : 8'd0;
  assign read_valid_o    = rd_valid_q;
  assign byte_stored_o   = stored_q;
  assign frame_status_o  = status_q;
  assign frame_latched_o = latched_q;

endmodule

/* rtl/core/rxpf_checker.sv */
// Port-level checks for the receive framer, bound to the top level.
`timescale 1ns / 1ps

module rxpf_port_checks (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_byte_o,
  input logic       read_valid_o,
  input logic       byte_stored_o,
  input logic [1:0] frame_status_o,
  input logic       frame_latched_o
);
  import rxpf_pkg::*;

  // stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a beat is either a read or a receive, never both
  a_read_xor_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_valid_o |-> !byte_stored_o && (frame_status_o == FS_NONE))
    else $error("read result carries receive flags");

  // empty or non-read returns zero data
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !read_valid_o |-> read_byte_o == 8'd0)
    else $error("read byte nonzero without read valid");

  // any frame verdict latches the frame
  a_status_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o != FS_NONE) |-> frame_latched_o)
    else $error("frame status without latch");

endmodule

bind rx_packet_framer_with_ring_buffer_top rxpf_port_checks u_rxpf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .read_byte_o     (read_byte_o),
  .read_valid_o    (read_valid_o),
  .byte_stored_o   (byte_stored_o),
  .frame_status_o  (frame_status_o),
  .frame_latched_o (frame_latched_o)
);

/* tb/rxpf_checker.sv */
// Scoreboard for the receive framer: predicts every result beat and compares it.
`timescale 1ns / 1ps

module rxpf_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] action_i,
  input  logic [7:0] data_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] read_byte_i,
  input  logic       read_valid_i,
  input  logic       byte_stored_i,
  input  logic [1:0] frame_status_i,
  input  logic       frame_latched_i,
  output int         fail_cnt_o,
  output int         pending_o,
  output int         done_cnt_o,
  output int         abort_cnt_o,
  output int         drop_cnt_o,
  output int         empty_rd_cnt_o
);
  import rxpf_pkg::*;

  typedef enum logic [2:0] {
    TRK_WAIT,
    TRK_LEN,
    TRK_PAYLOAD,
    TRK_TAIL,
    TRK_SUM,
    TRK_END1,
    TRK_END2
  } trk_step_e;

  typedef struct packed {
    logic [7:0] rd_byte;
    logic       rd_ok;
    logic       stored;
    status_e    status;
    logic       latched;
  } rx_result_t;

  // predictor state
  logic [7:0]         ring_mem [RING_DEPTH];
  logic [RING_AW-1:0] rd_ptr;
  logic [RING_AW-1:0] wr_ptr;
  logic               ring_full;
  trk_step_e          trk_step;
  logic [7:0]         payload_left;
  logic               frame_latch;

  rx_result_t result_q [$];
  int n_fail;
  int n_out;
  int n_done;
  int n_abort;
  int n_drop;
  int n_empty;

  assign fail_cnt_o     = n_fail;
  assign done_cnt_o     = n_done;
  assign abort_cnt_o    = n_abort;
  assign drop_cnt_o     = n_drop;
  assign empty_rd_cnt_o = n_empty;

  function automatic logic [RING_AW-1:0] ptr_next(input logic [RING_AW-1:0] p);
    return (p == RING_AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // one step of the frame tracker on an accepted byte
  function automatic status_e track_byte(input logic [7:0] b);
    status_e st;
    st = FS_NONE;
    case (trk_step)
      TRK_WAIT: begin
        if (b == MARK_START) trk_step = TRK_LEN;
      end
      TRK_LEN: begin
        payload_left = b;
        trk_step = (b == 8'd0) ? TRK_TAIL : TRK_PAYLOAD;
      end
      TRK_PAYLOAD: begin
        if (payload_left != 8'd0) payload_left = payload_left - 8'd1;
        if (payload_left == 8'd0) trk_step = TRK_TAIL;
      end
      TRK_TAIL: begin
        if (b == MARK_TAIL) begin
          trk_step = TRK_SUM;
        end else begin
          frame_latch = 1'b1;
          trk_step = TRK_WAIT;
          st = FS_ABORT;
        end
      end
      TRK_SUM: begin
        trk_step = TRK_END1;
      end
      TRK_END1: begin
        if (b == MARK_END1) begin
          trk_step = TRK_END2;
        end else begin
          frame_latch = 1'b1;
          trk_step = TRK_WAIT;
          st = FS_ABORT;
        end
      end
      TRK_END2: begin
        // a wrong second end byte just keeps us waiting
        if (b == MARK_END2) begin
          frame_latch = 1'b1;
          trk_step = TRK_WAIT;
          st = FS_DONE;
        end
      end
      default: begin
        trk_step = TRK_WAIT;
      end
    endcase
    return st;
  endfunction

  function automatic rx_result_t frame_result(input action_e act, input logic [7:0] b);
    rx_result_t r;
    r = '0;
    case (act)
      ACT_RX: begin
        if (!frame_latch) begin
          if (!ring_full) begin
            ring_mem[wr_ptr] = b;
            wr_ptr = ptr_next(wr_ptr);
            if (wr_ptr == rd_ptr) ring_full = 1'b1;
            r.stored = 1'b1;
          end else begin
            n_drop++;
          end
          r.status = track_byte(b);
        end
      end
      ACT_READ: begin
        if (ring_full || rd_ptr != wr_ptr) begin
          r.rd_byte = ring_mem[rd_ptr];
          r.rd_ok = 1'b1;
          rd_ptr = ptr_next(rd_ptr);
          ring_full = 1'b0;
        end else begin
          n_empty++;
        end
      end
      ACT_RELEASE: begin
        frame_latch = 1'b0;
      end
      default: ;
    endcase
    r.latched = frame_latch;
    if (r.status == FS_DONE) n_done++;
    if (r.status == FS_ABORT) n_abort++;
    return r;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      n_fail++;
      if (n_fail <= 10)
        $display("result beat %0d: %s expected 'h%0h, got 'h%0h", n_out, name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rx_result_t exp_r;
    if (!rst_ni) begin
      rd_ptr       = '0;
      wr_ptr       = '0;
      ring_full    = 1'b0;
      trk_step     = TRK_WAIT;
      payload_left = 8'd0;
      frame_latch  = 1'b0;
      result_q.delete();
      pending_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        result_q.push_back(frame_result(action_e'(action_i), data_byte_i));
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("result beat %0d arrived with nothing expected", n_out);
        end else begin
          exp_r = result_q.pop_front();
          check_field("read_byte", exp_r.rd_byte, read_byte_i);
          check_field("read_valid", exp_r.rd_ok, read_valid_i);
          check_field("byte_stored", exp_r.stored, byte_stored_i);
          check_field("frame_status", exp_r.status, frame_status_i);
          check_field("frame_latched", exp_r.latched, frame_latched_i);
        end
        n_out++;
      end
      pending_o <= result_q.size();
    end
  end

endmodule

/* tb/tb_rx_packet_framer_with_ring_buffer_top.sv */
// Testbench top for the receive framer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_rx_packet_framer_with_ring_buffer_top;
  import rxpf_pkg::*;

  // Cycle limit for the watchdog, far longer than the slowest legal run.
  localparam int CYCLE_LIMIT = 200000;
  // Target for counted input beats (ignored bytes are not counted).
  localparam int N_ITEMS     = 1800;
  // Length of the single long receiver hold-off.
  localparam int HOLD_CYCLES = 300;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [1:0] rx_action  = ACT_RX;
  logic [7:0] data_byte  = 8'd0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       byte_stored;
  logic [1:0] frame_status;
  logic       frame_latched;

  int fail_cnt;
  int pending;
  int frames_done;
  int frames_aborted;
  int full_drops;
  int empty_reads;

  int beats_sent = 0;
  int cycles     = 0;
  bit calm       = 1'b0;   // no idling on either side while set
  bit hold_req   = 1'b0;   // ask the receiver for its long hold-off
  bit hold_done  = 1'b0;

  rx_packet_framer_with_ring_buffer_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (rx_action),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .read_byte_o    (read_byte),
    .read_valid_o   (read_valid),
    .byte_stored_o  (byte_stored),
    .frame_status_o (frame_status),
    .frame_latched_o(frame_latched)
  );

  // Scoreboard sits on both channels and reports back failures and progress.
  rxpf_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .action_i       (rx_action),
    .data_byte_i    (data_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .read_byte_i    (read_byte),
    .read_valid_i   (read_valid),
    .byte_stored_i  (byte_stored),
    .frame_status_i (frame_status),
    .frame_latched_i(frame_latched),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending),
    .done_cnt_o     (frames_done),
    .abort_cnt_o    (frames_aborted),
    .drop_cnt_o     (full_drops),
    .empty_rd_cnt_o (empty_reads)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("rx_packet_framer_with_ring_buffer_top: mismatch");
    $finish;
  end

  // Receiver side. Drops ready about 6% of cycles, never while calm. Once the
  // stimulus asks, it holds ready low for a long stretch so the result
  // register fills and the block has to stall its input.
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 6);
      end
    end
  end

  // Offer one beat and wait for its handshake. Occasionally drops valid
  // first; valid is never lowered while a beat is on offer.
  task automatic send_beat(input action_e act, input logic [7:0] b, input bit counted = 1'b1);
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    rx_action <= act;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counted) beats_sent++;
  endtask

  // Any byte except the start marker, so idle traffic cannot open a frame.
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    return (b == MARK_START) ? ~b : b;
  endfunction

  // Reads sprinkled between frame bytes keep the ring level wandering.
  task automatic maybe_read();
    if ($urandom_range(99) < 50) send_beat(ACT_READ, 8'($urandom_range(255)));
  endtask

  // Mostly well-formed frame with random length and content; a minority get a
  // bad tail, a bad first end byte, or a stray byte before the final 0x0A.
  // Every path ends latched, then a few bytes hit the latch and a release.
  task automatic send_frame();
    int         pick;
    int         len;
    logic [7:0] tail;
    logic [7:0] end1;
    logic [7:0] stray;
    pick = $urandom_range(99);
    if (pick < 80)      len = $urandom_range(6);
    else if (pick < 95) len = $urandom_range(40, 7);
    else                len = $urandom_range(255, 200);
    maybe_read();
    send_beat(ACT_RX, MARK_START);
    maybe_read();
    send_beat(ACT_RX, 8'(len));
    for (int i = 0; i < len; i++) begin
      maybe_read();
      send_beat(ACT_RX, 8'($urandom_range(255)));
    end
    tail = ($urandom_range(99) < 90) ? MARK_TAIL : 8'($urandom_range(255));
    send_beat(ACT_RX, tail);
    if (tail == MARK_TAIL) begin
      maybe_read();
      send_beat(ACT_RX, 8'($urandom_range(255)));   // checksum, not checked by the block
      end1 = ($urandom_range(99) < 90) ? MARK_END1 : 8'($urandom_range(255));
      send_beat(ACT_RX, end1);
      if (end1 == MARK_END1) begin
        if ($urandom_range(99) < 15) begin
          stray = 8'($urandom_range(255));
          send_beat(ACT_RX, (stray == MARK_END2) ? ~stray : stray);
        end
        send_beat(ACT_RX, MARK_END2);
      end
    end
    repeat ($urandom_range(2)) send_beat(ACT_RX, 8'($urandom_range(255)), 1'b0);
    send_beat(ACT_RELEASE, 8'($urandom_range(255)));
  endtask

  // Short mixed traffic: the rare start byte here makes broken frames.
  task automatic send_noise();
    int pick;
    repeat ($urandom_range(8, 1)) begin
      pick = $urandom_range(99);
      if (pick < 55)
        send_beat(ACT_RX, ($urandom_range(99) < 5) ? MARK_START : noise_byte());
      else if (pick < 85)
        send_beat(ACT_READ, 8'($urandom_range(255)));
      else
        send_beat(ACT_RELEASE, 8'($urandom_range(255)));
    end
  endtask

  // Overfill the ring, run a frame through the tracker while full, then
  // drain past empty. Releases along the way undo any stray latch.
  task automatic flood_ring();
    for (int i = 0; i < RING_DEPTH + 40; i++) begin
      if (i % 32 == 0) send_beat(ACT_RELEASE, 8'($urandom_range(255)));
      send_beat(ACT_RX, noise_byte());
    end
    send_frame();
    repeat (RING_DEPTH + 4) send_beat(ACT_READ, 8'($urandom_range(255)));
  endtask

  initial begin : stim
    int  pick;
    bit  flooded;
    flooded = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: read on empty ring, release while open.
    send_beat(ACT_READ, 8'hFF);
    send_beat(ACT_RELEASE, 8'h00);
    // Zero-length frame with a wrong second end byte, then a good one.
    send_beat(ACT_RX, MARK_START);
    send_beat(ACT_RX, 8'h00);
    send_beat(ACT_RX, MARK_TAIL);
    send_beat(ACT_RX, 8'hFF);
    send_beat(ACT_RX, MARK_END1);
    send_beat(ACT_RX, 8'h0B);
    send_beat(ACT_RX, MARK_END2);
    // Byte while latched is dropped, then reopen.
    send_beat(ACT_RX, 8'h00, 1'b0);
    send_beat(ACT_RELEASE, 8'hFF);
    // One payload byte, then bad tail: abort.
    send_beat(ACT_RX, MARK_START);
    send_beat(ACT_RX, 8'h01);
    send_beat(ACT_RX, 8'hFF);
    send_beat(ACT_RX, 8'h00);
    send_beat(ACT_RELEASE, 8'h00);
    // Bad first end byte: abort.
    send_beat(ACT_RX, MARK_START);
    send_beat(ACT_RX, 8'h00);
    send_beat(ACT_RX, MARK_TAIL);
    send_beat(ACT_RX, 8'h00);
    send_beat(ACT_RX, 8'h0E);
    send_beat(ACT_RELEASE, 8'h00);
    // Pop the oldest stored bytes.
    send_beat(ACT_READ, 8'h00);
    send_beat(ACT_READ, 8'hFF);

    // Random part, episode by episode.
    while (beats_sent < N_ITEMS) begin
      calm = (beats_sent >= 900 && beats_sent < 1200);
      if (beats_sent >= 1300) hold_req = 1'b1;
      if (!flooded && beats_sent >= 500) begin
        flood_ring();
        flooded = 1'b1;
      end else begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_frame();
        end else if (pick < 90) begin
          send_noise();
        end else begin
          repeat ($urandom_range(20, 1)) send_beat(ACT_READ, 8'($urandom_range(255)));
        end
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain: pending is a registered copy that trails the handshake, so step first.
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);

    $display("%0d beats sent, %0d frames completed, %0d aborted", beats_sent, frames_done,
             frames_aborted);
    $display("%0d bytes dropped on a full ring, %0d reads on an empty ring", full_drops,
             empty_reads);
    if (fail_cnt == 0 && pending == 0) begin
      $display("rx_packet_framer_with_ring_buffer_top: match");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("rx_packet_framer_with_ring_buffer_top: mismatch");
    end
    $finish;
  end

endmodule
